// ===== hdl/etsf_pkg.sv =====
// Shared package for the totient unit: widths, sieve constants, sequencer states
// and the divider status bundle.
// No dependencies.
`default_nettype none

package etsf_pkg;

   // fixed width of n, totient and every value on the query path
   localparam int VAL_W = 17;

   // default table depth (entries 0 .. MAX_N-1)
   localparam int MAX_N_DEF = 131072;

   // sieve constants
   localparam int EVEN_PRIME      = 2;
   localparam int FIRST_ODD_PRIME = 3;
   localparam int FIRST_EVEN_COMP = 4;

   // divider step counter width
   localparam int DIV_CNT_W = $clog2(VAL_W);

   // sequencer states
   typedef enum logic [3:0] {
      ST_FILL,
      ST_SIEVE_SQ,
      ST_SIEVE_CHKI,
      ST_SIEVE_CHKJ,
      ST_IDLE,
      ST_LOOP,
      ST_LOOKUP,
      ST_DIVIDE,
      ST_FINISH
   } etsf_state_type;

   // divider status toward the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } etsf_div_status_type;

endpackage : etsf_pkg

`default_nettype wire

// ===== hdl/euler_totient_spf_factor_unit.sv =====
// Euler totient unit: sieve-built smallest-prime-factor table and a factor loop
// around etsf_divider. Depends on etsf_pkg, etsf_divider.
// Per request: a loop check, a table lookup with the multiply and a divide for each prime
// factor of n counted with multiplicity, then the finish state; n of one, zero or out of
// range reaches finish without a divide. req_stall is high outside idle: one request at a time.
// Reset: fills all MAX_N entries, then checks each sieve candidate and marks its multiples.
`default_nettype none

module euler_totient_spf_factor_unit
   import etsf_pkg::*;
#(
   parameter int MAX_N = MAX_N_DEF
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire logic [VAL_W-1:0] req_value_n,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [VAL_W-1:0]      rsp_totient,
   output logic                  rsp_is_prime,
   output logic                  rsp_range_error
);

   localparam int IDX_W = $clog2(MAX_N);
   localparam int SQ_W  = 2 * IDX_W;
   localparam int J_W   = IDX_W + 1;

   // smallest-prime-factor table
   logic [IDX_W-1:0] spf_mem [MAX_N];
   logic [IDX_W-1:0] rd_data_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [IDX_W-1:0] wr_data;
   logic             wr_en;

   etsf_state_type   state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [J_W-1:0]   j_ff, j_in;
   logic [VAL_W-1:0] n_ff, n_in;
   logic [VAL_W-1:0] x_ff, x_in;
   logic [VAL_W-1:0] phi_ff, phi_in;
   logic [VAL_W-1:0] prev_ff, prev_in;
   logic             err_ff, err_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_totient_ff, rsp_totient_in;
   logic             rsp_is_prime_ff, rsp_is_prime_in;
   logic             rsp_range_error_ff, rsp_range_error_in;

   logic [SQ_W-1:0]  sq;
   logic [J_W-1:0]   j_next;
   logic [IDX_W-1:0] fill_val;
   logic [VAL_W-1:0] p_val;
   logic [VAL_W-1:0] mul_b;
   logic             req_xfer;
   logic             n_bad;
   logic             slot_free;

   logic                div_start;
   logic [VAL_W-1:0]    div_quo;
   etsf_div_status_type div_stat;

   // single divider for the factor loop
   etsf_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (x_ff),
      .divisor  (p_val),
      .quotient (div_quo),
      .status   (div_stat)
   );

   // table port, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         spf_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= spf_mem[rd_addr];
   end

   // sieve helpers
   assign sq     = SQ_W'(i_ff) * SQ_W'(i_ff);
   assign j_next = j_ff + J_W'(i_ff);

   // first pass: identity, with even numbers from four marked by two
   always_comb begin
      if (k_ff == IDX_W'(0)) begin
         fill_val = '0;
      end else if (k_ff == IDX_W'(1)) begin
         fill_val = IDX_W'(1);
      end else if (!k_ff[0] && k_ff >= IDX_W'(FIRST_EVEN_COMP)) begin
         fill_val = IDX_W'(EVEN_PRIME);
      end else begin
         fill_val = k_ff;
      end
   end

   // query helpers
   assign p_val     = VAL_W'(rd_data_ff);
   assign mul_b     = (p_val == prev_ff) ? p_val : p_val - 1'b1;
   assign req_xfer  = req_valid && !req_stall;
   assign n_bad     = (req_value_n == '0) || (32'(req_value_n) >= 32'(MAX_N));
   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);

   // sequencer state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_FILL;
         k_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      i_ff               <= i_in;
      j_ff               <= j_in;
      n_ff               <= n_in;
      x_ff               <= x_in;
      phi_ff             <= phi_in;
      prev_ff            <= prev_in;
      err_ff             <= err_in;
      rsp_totient_ff     <= rsp_totient_in;
      rsp_is_prime_ff    <= rsp_is_prime_in;
      rsp_range_error_ff <= rsp_range_error_in;
   end

   // next state and outputs
   always_comb begin
      state_in           = state_ff;
      k_in               = k_ff;
      i_in               = i_ff;
      j_in               = j_ff;
      n_in               = n_ff;
      x_in               = x_ff;
      phi_in             = phi_ff;
      prev_in            = prev_ff;
      err_in             = err_ff;
      rd_addr            = IDX_W'(x_ff);
      wr_en              = 1'b0;
      wr_addr            = k_ff;
      wr_data            = fill_val;
      div_start          = 1'b0;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_totient_in     = rsp_totient_ff;
      rsp_is_prime_in    = rsp_is_prime_ff;
      rsp_range_error_in = rsp_range_error_ff;

      unique case (state_ff)
         ST_FILL: begin
            wr_en = 1'b1;
            k_in  = k_ff + 1'b1;
            if (k_ff == IDX_W'(MAX_N - 1)) begin
               i_in     = IDX_W'(FIRST_ODD_PRIME);
               state_in = ST_SIEVE_SQ;
            end
         end
         ST_SIEVE_SQ: begin
            // check i*i against the depth and read entry i
            rd_addr = i_ff;
            if (sq < SQ_W'(MAX_N)) begin
               j_in     = J_W'(sq);
               state_in = ST_SIEVE_CHKI;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SIEVE_CHKI: begin
            // i is prime when still unmarked; start at i*i, read it now
            rd_addr = j_ff[IDX_W-1:0];
            if (rd_data_ff == i_ff) begin
               state_in = ST_SIEVE_CHKJ;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SIEVE_SQ;
            end
         end
         ST_SIEVE_CHKJ: begin
            // mark j if unmarked, read the next multiple in the same cycle
            rd_addr = j_next[IDX_W-1:0];
            wr_addr = j_ff[IDX_W-1:0];
            wr_data = i_ff;
            wr_en   = (rd_data_ff == j_ff[IDX_W-1:0]);
            if (j_next < J_W'(MAX_N)) begin
               j_in = j_next;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SIEVE_SQ;
            end
         end
         ST_IDLE: begin
            if (req_xfer) begin
               n_in    = req_value_n;
               x_in    = req_value_n;
               prev_in = '0;
               err_in  = n_bad;
               if (n_bad) begin
                  phi_in   = '0;
                  state_in = ST_FINISH;
               end else begin
                  phi_in   = VAL_W'(1);
                  state_in = ST_LOOP;
               end
            end
         end
         ST_LOOP: begin
            // read spf of x while x is above one
            if (x_ff > VAL_W'(1)) begin
               state_in = ST_LOOKUP;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_LOOKUP: begin
            if (p_val < VAL_W'(EVEN_PRIME)) begin
               state_in = ST_FINISH;
            end else begin
               phi_in    = VAL_W'(phi_ff * mul_b);
               prev_in   = p_val;
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               x_in     = div_quo;
               state_in = ST_LOOP;
            end
         end
         ST_FINISH: begin
            // load the output register once it is free
            if (slot_free) begin
               rsp_valid_in       = 1'b1;
               rsp_totient_in     = phi_ff;
               rsp_is_prime_in    = !err_ff && (phi_ff == n_ff - 1'b1);
               rsp_range_error_in = err_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_totient     = rsp_totient_ff;
   assign rsp_is_prime    = rsp_is_prime_ff;
   assign rsp_range_error = rsp_range_error_ff;

`ifndef SYNTHESIS
   a_err_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_range_error_ff) |-> (rsp_totient_ff == '0 && !rsp_is_prime_ff))
      else $error("range error with nonzero result");

   a_prime_no_err: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_is_prime_ff) |-> !rsp_range_error_ff)
      else $error("prime flag on an error result");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_DIVIDE))
      else $error("divider finished outside the divide state");

   a_x_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOP) |-> (x_ff != '0))
      else $error("factor loop reached zero");
`endif

endmodule : euler_totient_spf_factor_unit

`default_nettype wire

// ===== hdl/etsf_divider.sv =====
// Restoring radix-2 divider for the factor loop, one quotient bit per cycle.
// Depends on etsf_pkg.
`default_nettype none

module etsf_divider
   import etsf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [VAL_W-1:0]    dividend,
   input  wire logic [VAL_W-1:0]    divisor,
   output logic [VAL_W-1:0]         quotient,
   output etsf_div_status_type      status
);

   logic [VAL_W:0]     rem_ff,  rem_in;
   logic [VAL_W-1:0]   quo_ff,  quo_in;
   logic [VAL_W-1:0]   dvs_ff,  dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;

   logic [VAL_W:0]     shifted;
   logic [VAL_W:0]     diff;

   // shift-subtract step
   assign shifted = {rem_ff[VAL_W-1:0], quo_ff[VAL_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[VAL_W]) begin
            rem_in = diff;
            quo_in = {quo_ff[VAL_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[VAL_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(VAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign quotient    = quo_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

`ifndef SYNTHESIS
   a_busy_done_excl: assert property (@(posedge clock) disable iff (reset)
      !(busy_ff && done_ff))
      else $error("divider busy and done together");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !start)
      else $error("divider started while busy");
`endif

endmodule : etsf_divider

`default_nettype wire

// ===== verif/etsf_totient_checker.sv =====
// Result checker for the totient unit: watches both channels, predicts each
// result by trial factoring and compares it field by field.
// Depends on etsf_pkg.
module etsf_totient_checker
   import etsf_pkg::*;
#(
   parameter int MAX_N = MAX_N_DEF
)
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_stall,
   input  wire logic [VAL_W-1:0] req_value_n,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_stall,
   input  wire logic [VAL_W-1:0] rsp_totient,
   input  wire logic             rsp_is_prime,
   input  wire logic             rsp_range_error,
   output int                    fail_count,
   output int                    pending_count
);

   typedef struct packed {
      logic [VAL_W-1:0] totient;
      logic             is_prime;
      logic             range_error;
   } totient_result_type;

   totient_result_type phi_expected_q [$];
   totient_result_type want;
   int                 mismatches = 0;

   // phi(n) by trial division; n of zero or past the table is an error
   function automatic totient_result_type predict_phi(input logic [VAL_W-1:0] n);
      totient_result_type r;
      int unsigned        rest;
      int unsigned        p;
      int unsigned        phi;
      r = '0;
      if (n == 0 || n >= MAX_N) begin
         r.range_error = 1'b1;
      end else begin
         rest = n;
         phi  = 1;
         for (p = 2; p * p <= rest; p++) begin
            if (rest % p == 0) begin
               phi  = phi * (p - 1);
               rest = rest / p;
               while (rest % p == 0) begin
                  phi  = phi * p;
                  rest = rest / p;
               end
            end
         end
         // leftover cofactor is a prime of multiplicity one
         if (rest > 1)
            phi = phi * (rest - 1);
         r.totient  = phi[VAL_W-1:0];
         r.is_prime = (phi == n - 1);
      end
      return r;
   endfunction

   // compare result transfers first, then record the new request transfer
   always @(posedge clock) begin
      if (reset) begin
         phi_expected_q.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (phi_expected_q.size() == 0) begin
               $error("unexpected result transfer: totient %0d", rsp_totient);
               mismatches++;
            end else begin
               want = phi_expected_q.pop_front();
               if (rsp_totient !== want.totient) begin
                  $error("totient mismatch: expected %0d, actual %0d",
                         want.totient, rsp_totient);
                  mismatches++;
               end
               if (rsp_is_prime !== want.is_prime) begin
                  $error("is_prime mismatch: expected %0d, actual %0d",
                         want.is_prime, rsp_is_prime);
                  mismatches++;
               end
               if (rsp_range_error !== want.range_error) begin
                  $error("range_error mismatch: expected %0d, actual %0d",
                         want.range_error, rsp_range_error);
                  mismatches++;
               end
            end
         end
         if (req_valid && !req_stall)
            phi_expected_q = {phi_expected_q, predict_phi(req_value_n)};
         pending_count <= phi_expected_q.size();
      end
      fail_count <= mismatches;
   end

endmodule

// ===== verif/tb_euler_totient_spf_factor_unit.sv =====
// Testbench top for euler_totient_spf_factor_unit: drives n values with random
// gaps and result stalls, gives the verdict. Depends on etsf_pkg,
// the unit and etsf_totient_checker.
module tb_euler_totient_spf_factor_unit
   import etsf_pkg::*;
();

   localparam int MAX_N         = MAX_N_DEF;
   localparam int RAND_ITEMS    = 630;
   localparam int QUIET_TAIL    = 80;
   localparam int SETTLE_CYCLES = 40;
   // limit covers the reset sieve and every item
   localparam int CYCLE_LIMIT   = 3_000_000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [VAL_W-1:0] req_value_n;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [VAL_W-1:0] rsp_totient;
   logic             rsp_is_prime;
   logic             rsp_range_error;
   logic             calm;
   int               fail_count;
   int               pending_count;
   int               cycle_count = 0;

   // corner values: zero, one, smallest primes, deep powers, prime squares,
   // primorials, the largest n
   int unsigned corner_n [20] = '{0, 1, 2, 3, 4, 6, 9, 12, 97, 30030, 120120,
                                  65536, 59049, 128881, 130321, 65537, 131071,
                                  131070, 1, 131069};
   int unsigned factor_pool [12] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 257, 359};

   euler_totient_spf_factor_unit #(.MAX_N(MAX_N)) dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value_n     (req_value_n),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_totient     (rsp_totient),
      .rsp_is_prime    (rsp_is_prime),
      .rsp_range_error (rsp_range_error)
   );

   etsf_totient_checker #(.MAX_N(MAX_N)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value_n     (req_value_n),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_totient     (rsp_totient),
      .rsp_is_prime    (rsp_is_prime),
      .rsp_range_error (rsp_range_error),
      .fail_count      (fail_count),
      .pending_count   (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // result side: random stall bursts unless calm
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!calm && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 8)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // random n: uniform, smooth products, prime powers, tiny, near the top, zero
   function automatic logic [VAL_W-1:0] pick_n();
      int unsigned v;
      int unsigned p;
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 30) begin
         v = $urandom_range(0, 2**VAL_W - 1);
      end else if (sel < 60) begin
         v = 1;
         repeat ($urandom_range(1, 17)) begin
            p = factor_pool[$urandom_range(0, 11)];
            if (v * p < MAX_N)
               v = v * p;
         end
      end else if (sel < 72) begin
         p = factor_pool[$urandom_range(0, 11)];
         v = p;
         repeat ($urandom_range(0, 16)) begin
            if (v * p < MAX_N)
               v = v * p;
         end
      end else if (sel < 82) begin
         v = $urandom_range(0, 40);
      end else if (sel < 94) begin
         v = $urandom_range(MAX_N - 200, 2**VAL_W - 1);
      end else begin
         v = 0;
      end
      return v[VAL_W-1:0];
   endfunction

   // one request transfer, optionally preceded by an idle burst
   task automatic transfer_n(input int unsigned n, input logic quiet);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_value_n <= n[VAL_W-1:0];
      do @(posedge clock); while (req_stall);
   endtask

   // hold the request side until every expected result has arrived
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // stimulus and verdict
   initial begin
      logic quiet;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_value_n <= '0;
      calm        <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      calm  <= 1'b0;

      foreach (corner_n[i])
         transfer_n(corner_n[i], 1'b0);
      drain_results();

      for (int k = 0; k < RAND_ITEMS; k++) begin
         quiet = (k >= RAND_ITEMS - QUIET_TAIL) || ((k / 60) % 4 == 2);
         calm <= quiet;
         if (k == RAND_ITEMS / 2)
            drain_results();
         transfer_n(pick_n(), quiet);
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/etsf_pkg.sv
hdl/etsf_divider.sv
hdl/euler_totient_spf_factor_unit.sv
verif/etsf_totient_checker.sv
verif/tb_euler_totient_spf_factor_unit.sv
